// ===== rtl/bsc_pkg.sv =====
// shared types and constants for the barometric compensation pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package bsc_pkg;

	// field widths
	localparam int unsigned RAW_W   = 24;
	localparam int unsigned CAL_W   = 16;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned TOUT_W  = 15;
	localparam int unsigned POUT_W  = 17;

	// internal widths
	localparam int unsigned DT_W    = 25;
	localparam int unsigned TEMP_W  = 20;
	localparam int unsigned OFF_W   = 42;
	localparam int unsigned SENS_W  = 41;
	localparam int unsigned P_W     = 29;

	// register indexes of the calibration port
	typedef enum logic [IDX_W-1:0] {
		CFG_C1 = 3'd0,
		CFG_C2 = 3'd1,
		CFG_C3 = 3'd2,
		CFG_C4 = 3'd3,
		CFG_C5 = 3'd4,
		CFG_C6 = 3'd5
	} cfg_idx_t;

	// compensation constants
	localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
	localparam logic signed [18:0] TEMP_VLOW = -19'sd1500;

	// output limits
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -20'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 20'sd8500;
	localparam logic signed [P_W-1:0]    PRES_MIN = 29'sd1000;
	localparam logic signed [P_W-1:0]    PRES_MAX = 29'sd120000;

	// cycles from an accepted start to the result strobe edge
	localparam int unsigned PIPE_DEPTH = 10;

	// calibration words C1..C6
	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} cal_t;

	// corrected terms handed from the front pipeline to the pressure stages
	typedef struct packed {
		logic                     valid;
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} comp_t;

endpackage

`default_nettype wire

// ===== rtl/bsc_cal_regs.sv =====
// calibration register file, six 16-bit words written through the config channel
// depends on bsc_pkg
`default_nettype none

module bsc_cal_regs
	import bsc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [CAL_W-1:0] wr_data,
	output cal_t                  cal
);

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_C1: begin
					cal_q.c1 <= wr_data;
				end
				CFG_C2: begin
					cal_q.c2 <= wr_data;
				end
				CFG_C3: begin
					cal_q.c3 <= wr_data;
				end
				CFG_C4: begin
					cal_q.c4 <= wr_data;
				end
				CFG_C5: begin
					cal_q.c5 <= wr_data;
				end
				CFG_C6: begin
					cal_q.c6 <= wr_data;
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	assign cal = cal_q;

endmodule

`default_nettype wire

// ===== rtl/bsc_comp_front.sv =====
// stages 1 to 6: dT, first-order terms and the low-temperature corrections
// depends on bsc_pkg
`default_nettype none

module bsc_comp_front
	import bsc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [RAW_W-1:0] raw_pressure,
	input  wire logic [RAW_W-1:0] raw_temperature,
	input  wire cal_t             cal,
	output comp_t                 comp
);

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1
	logic [RAW_W-1:0]       d1_s1;
	logic signed [DT_W-1:0] dt_s1;
	// stage 2
	logic [RAW_W-1:0]       d1_s2;
	logic signed [41:0]     prod_t_s2;
	logic signed [41:0]     prod_off_s2;
	logic signed [41:0]     prod_sens_s2;
	logic [48:0]            dtsq_s2;
	// stage 3
	logic [RAW_W-1:0]         d1_s3;
	logic signed [18:0]       temp_s3;
	logic signed [OFF_W-1:0]  off_s3;
	logic signed [SENS_W-1:0] sens_s3;
	logic [17:0]              t2_s3;
	// stage 4
	logic [RAW_W-1:0]         d1_s4;
	logic signed [18:0]       temp_s4;
	logic signed [OFF_W-1:0]  off_s4;
	logic signed [SENS_W-1:0] sens_s4;
	logic [17:0]              t2_s4;
	logic [35:0]              sq1_s4;
	logic [35:0]              sq2_s4;
	logic                     low_s4;
	logic                     vlow_s4;
	// stage 5
	logic [RAW_W-1:0]         d1_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	logic signed [OFF_W-1:0]  off_s5;
	logic signed [SENS_W-1:0] sens_s5;
	logic [39:0]              off2_s5;
	logic [38:0]              sens2_s5;
	// stage 6
	logic [RAW_W-1:0]         d1_s6;
	logic signed [TEMP_W-1:0] temp_s6;
	logic signed [OFF_W-1:0]  off_s6;
	logic signed [SENS_W-1:0] sens_s6;

	// combinational terms
	logic signed [DT_W-1:0] dt_in;
	logic signed [49:0]     dtsq_full;
	logic signed [18:0]     dm;
	logic signed [18:0]     dp;
	logic signed [37:0]     sq1_full;
	logic signed [37:0]     sq2_full;
	logic [41:0]            off2_a;
	logic [41:0]            off2_b;
	logic [41:0]            off2_sum;
	logic [38:0]            sens2_sum;

	always_comb begin
		dt_in     = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'd0});
		dtsq_full = dt_s1 * dt_s1;
		dm        = temp_s3 - TEMP_REF;
		dp        = temp_s3 - TEMP_VLOW;
		sq1_full  = dm * dm;
		sq2_full  = dp * dp;
		off2_a    = (42'(sq1_s4) * 42'd61) >> 4;
		off2_b    = 42'(sq2_s4) * 42'd15;
		off2_sum  = off2_a + (vlow_s4 ? off2_b : '0);
		sens2_sum = 39'({sq1_s4, 1'b0}) + (vlow_s4 ? {sq2_s4, 3'b000} : 39'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// s1: offset of the temperature reading
		d1_s1 <= raw_pressure;
		dt_s1 <= dt_in;

		// s2: the four products on dT
		d1_s2        <= d1_s1;
		prod_t_s2    <= dt_s1 * $signed({1'b0, cal.c6});
		prod_off_s2  <= dt_s1 * $signed({1'b0, cal.c4});
		prod_sens_s2 <= dt_s1 * $signed({1'b0, cal.c3});
		dtsq_s2      <= dtsq_full[48:0];

		// s3: first-order temperature, offset and sensitivity
		d1_s3   <= d1_s2;
		temp_s3 <= $signed(prod_t_s2[41:23]) + TEMP_REF;
		off_s3  <= $signed({9'd0, cal.c2, 17'd0}) + (prod_off_s2 >>> 6);
		sens_s3 <= $signed({9'd0, cal.c1, 16'd0}) + SENS_W'(prod_sens_s2 >>> 7);
		t2_s3   <= dtsq_s2[48:31];

		// s4: squared distances from the two temperature corners
		d1_s4   <= d1_s3;
		temp_s4 <= temp_s3;
		off_s4  <= off_s3;
		sens_s4 <= sens_s3;
		t2_s4   <= t2_s3;
		sq1_s4  <= sq1_full[35:0];
		sq2_s4  <= sq2_full[35:0];
		low_s4  <= temp_s3 < TEMP_REF;
		vlow_s4 <= temp_s3 < TEMP_VLOW;

		// s5: second-order terms, zero above the reference temperature
		d1_s5    <= d1_s4;
		temp_s5  <= TEMP_W'(temp_s4) - $signed({2'b00, (low_s4 ? t2_s4 : 18'd0)});
		off_s5   <= off_s4;
		sens_s5  <= sens_s4;
		off2_s5  <= low_s4 ? off2_sum[39:0] : 40'd0;
		sens2_s5 <= low_s4 ? sens2_sum : 39'd0;

		// s6: apply the corrections
		d1_s6   <= d1_s5;
		temp_s6 <= temp_s5;
		off_s6  <= off_s5 - $signed({2'b00, off2_s5});
		sens_s6 <= sens_s5 - $signed({2'b00, sens2_s5});
	end

	assign comp.valid = v_s6;
	assign comp.d1    = d1_s6;
	assign comp.temp  = temp_s6;
	assign comp.off   = off_s6;
	assign comp.sens  = sens_s6;

endmodule

`default_nettype wire

// ===== rtl/bsc_pres_back.sv =====
// stages 7 to 10: split D1 x SENS product, pressure scaling and output clamp
// depends on bsc_pkg
`default_nettype none

module bsc_pres_back
	import bsc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire comp_t                    comp,
	output logic                          result_valid,
	output logic signed [TOUT_W-1:0]      temperature,
	output logic [POUT_W-1:0]             pressure,
	output logic                          out_of_range
);

	logic v_s7, v_s8, v_s9, v_s10;

	// stage 7: partial products
	logic [47:0]              lo_s7;
	logic signed [41:0]       hi_s7;
	logic signed [OFF_W-1:0]  off_s7;
	logic signed [TEMP_W-1:0] temp_s7;
	// stage 8: full 64-bit product
	logic signed [63:0]       prod_s8;
	logic signed [OFF_W-1:0]  off_s8;
	logic signed [TEMP_W-1:0] temp_s8;
	// stage 9: unclamped pressure
	logic signed [P_W-1:0]    p_s9;
	logic signed [TEMP_W-1:0] temp_s9;
	// stage 10: clamped outputs
	logic signed [TOUT_W-1:0] temp_s10;
	logic [POUT_W-1:0]        pres_s10;
	logic                     oor_s10;

	logic signed [43:0]       diff;
	logic signed [TEMP_W-1:0] temp_clamp;
	logic signed [P_W-1:0]    pres_clamp;
	logic                     temp_sat;
	logic                     pres_sat;

	always_comb begin
		diff = 44'(prod_s8 >>> 21) - 44'(off_s8);

		temp_clamp = temp_s9;
		temp_sat   = 1'b0;
		if (temp_s9 < TEMP_MIN) begin
			temp_clamp = TEMP_MIN;
			temp_sat   = 1'b1;
		end else if (temp_s9 > TEMP_MAX) begin
			temp_clamp = TEMP_MAX;
			temp_sat   = 1'b1;
		end

		pres_clamp = p_s9;
		pres_sat   = 1'b0;
		if (p_s9 < PRES_MIN) begin
			pres_clamp = PRES_MIN;
			pres_sat   = 1'b1;
		end else if (p_s9 > PRES_MAX) begin
			pres_clamp = PRES_MAX;
			pres_sat   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s7  <= comp.valid;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		// sens = hi * 2^24 + lo, hi signed, lo unsigned
		lo_s7   <= 48'(comp.d1) * 48'(comp.sens[23:0]);
		hi_s7   <= $signed({1'b0, comp.d1}) * $signed(comp.sens[40:24]);
		off_s7  <= comp.off;
		temp_s7 <= comp.temp;

		prod_s8 <= (64'(hi_s7) <<< 24) + $signed({16'd0, lo_s7});
		off_s8  <= off_s7;
		temp_s8 <= temp_s7;

		p_s9    <= $signed(diff[43:15]);
		temp_s9 <= temp_s8;

		temp_s10 <= temp_clamp[TOUT_W-1:0];
		pres_s10 <= pres_clamp[POUT_W-1:0];
		oor_s10  <= temp_sat | pres_sat;
	end

	assign result_valid = v_s10;
	assign temperature  = temp_s10;
	assign pressure     = pres_s10;
	assign out_of_range = oor_s10;

endmodule

`default_nettype wire

// ===== rtl/baro_sensor_compensation.sv =====
// top level of the barometric sensor compensation pipeline
// depends on bsc_pkg, bsc_cal_regs, bsc_comp_front, bsc_pres_back
//
// channel   direction  signals                                   transfer when
// -------   ---------  ----------------------------------------  ---------------------------
// command   in         start, busy, raw_pressure, raw_temperature start && !busy
// result    out        result_valid, temperature, pressure,       result_valid (one cycle)
//                      out_of_range
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// a conversion pair enters on any cycle; its result strobe comes once it has passed every register stage
// latency is set by the ten register stages of the datapath, throughput is one pair per cycle
// busy stays low: the pipeline has no stall path and the receiver cannot hold results off
// arst_n clears the stage valid bits and the calibration words; data registers are not reset
// calibration must be written through cfg while no pair is in flight; the block does not enforce it
`default_nettype none

module baro_sensor_compensation
	import bsc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// command channel
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [RAW_W-1:0]        raw_pressure,
	input  wire logic [RAW_W-1:0]        raw_temperature,
	// calibration write channel
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [IDX_W-1:0]        cfg_index,
	input  wire logic [CAL_W-1:0]        cfg_data,
	// result channel
	output logic                         result_valid,
	output logic signed [TOUT_W-1:0]     temperature,
	output logic [POUT_W-1:0]            pressure,
	output logic                         out_of_range
);

	cal_t  cal;
	comp_t comp;
	logic  accept;

	// pipeline takes a pair every cycle, no back pressure
	assign busy      = 1'b0;
	assign accept    = start & ~busy;
	// register file is always writable
	assign cfg_ready = 1'b1;

	// C1..C6
	bsc_cal_regs u_cal_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cal      (cal)
	);

	// dT, first order terms and low / very-low temperature corrections
	bsc_comp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (accept),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.cal             (cal),
		.comp            (comp)
	);

	// 64-bit D1 x SENS product, pressure scaling and saturation
	bsc_pres_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.comp         (comp),
		.result_valid (result_valid),
		.temperature  (temperature),
		.pressure     (pressure),
		.out_of_range (out_of_range)
	);

	// every accepted pair yields a result strobe once it has passed through the pipeline
	a_start_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_DEPTH result_valid)
		else $error("accepted pair produced no result");

	// no strobe without a matching accepted pair
	a_result_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept, PIPE_DEPTH))
		else $error("result without an accepted pair");

	// saturated outputs stay inside the operating range
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (temperature >= -15'sd4000 && temperature <= 15'sd8500))
		else $error("temperature outside operating range");

	a_pres_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pressure >= 17'd1000 && pressure <= 17'd120000))
		else $error("pressure outside operating range");

endmodule

`default_nettype wire

// ===== test/baro_sensor_compensation_tb.sv =====
// self-checking testbench for baro_sensor_compensation: directed and random conversion pairs
// depends on bsc_pkg and the baro_sensor_compensation RTL; needs no files or arguments
`default_nettype none

module baro_sensor_compensation_tb;
	import bsc_pkg::*;

	// one conversion pair as sent on the command channel
	typedef struct packed {
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
	} conv_pair_t;

	// one compensated reading as seen on the result channel
	typedef struct packed {
		logic signed [TOUT_W-1:0] temperature;
		logic [POUT_W-1:0]        pressure;
		logic                     flag;
	} reading_t;

	localparam int     RESET_CYCLES   = 11;
	localparam int     STALL_LIMIT    = 2000;
	localparam int     PHASES         = 10;
	localparam int     PHASE_ITEMS    = 100;
	localparam longint RAW_MAX        = (64'sd1 << RAW_W) - 1;
	localparam longint NOMINAL_D1     = 64'sd6465444;
	localparam longint SPREAD         = 64'sd1 << 21;
	// datasheet typical calibration words
	localparam cal_t   TYPICAL_CAL    = '{c1: 16'd46372, c2: 16'd43981, c3: 16'd29059,
		c4: 16'd27842, c5: 16'd31553, c6: 16'd28165};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [RAW_W-1:0]         raw_pressure = '0;
	logic [RAW_W-1:0]         raw_temperature = '0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [IDX_W-1:0]         cfg_index = '0;
	logic [CAL_W-1:0]         cfg_data = '0;
	logic                     result_valid;
	logic signed [TOUT_W-1:0] temperature;
	logic [POUT_W-1:0]        pressure;
	logic                     out_of_range;

	// testbench copy of the calibration registers, reset to zero like the block
	cal_t         cal = '0;
	conv_pair_t   pending_pairs[$];
	reading_t     expected_readings[$];
	int           sender_idle_pct = 33;
	int           failures = 0;
	int           pairs_sent = 0;
	int           readings_checked = 0;
	int           cal_sets = 1;
	int           stall_cycles = 0;

	always #2 clk = ~clk;

	baro_sensor_compensation DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.result_valid    (result_valid),
		.temperature     (temperature),
		.pressure        (pressure),
		.out_of_range    (out_of_range)
	);

	// first and second order compensation in exact 64-bit arithmetic
	// >>> on a signed longint floors, which is the rounding the block must match
	function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
		input logic [RAW_W-1:0] d2_raw);
		longint   d1, dt, temp_c, offset, sens, t2, off2, sens2, sq, pres;
		reading_t r;
		d1     = longint'(d1_raw);
		dt     = longint'(d2_raw) - longint'(cal.c5) * 256;
		temp_c = longint'(TEMP_REF) + ((dt * longint'(cal.c6)) >>> 23);
		offset = longint'(cal.c2) * 131072 + ((longint'(cal.c4) * dt) >>> 6);
		sens   = longint'(cal.c1) * 65536 + ((longint'(cal.c3) * dt) >>> 7);
		t2     = 0;
		off2   = 0;
		sens2  = 0;
		// low temperature correction below 20.00 C
		if (temp_c < longint'(TEMP_REF)) begin
			sq    = (temp_c - longint'(TEMP_REF)) * (temp_c - longint'(TEMP_REF));
			t2    = (dt * dt) >>> 31;
			off2  = (61 * sq) >>> 4;
			sens2 = 2 * sq;
			// very low temperature term below -15.00 C
			if (temp_c < longint'(TEMP_VLOW)) begin
				sq    = (temp_c - longint'(TEMP_VLOW)) * (temp_c - longint'(TEMP_VLOW));
				off2  = off2 + 15 * sq;
				sens2 = sens2 + 8 * sq;
			end
		end
		temp_c = temp_c - t2;
		offset = offset - off2;
		sens   = sens - sens2;
		pres   = (((d1 * sens) >>> 21) - offset) >>> 15;
		// clamp to the operating range, flag any clamp
		r.flag = 1'b0;
		if (temp_c < longint'(TEMP_MIN)) begin
			temp_c = longint'(TEMP_MIN);
			r.flag = 1'b1;
		end
		if (temp_c > longint'(TEMP_MAX)) begin
			temp_c = longint'(TEMP_MAX);
			r.flag = 1'b1;
		end
		if (pres < longint'(PRES_MIN)) begin
			pres   = longint'(PRES_MIN);
			r.flag = 1'b1;
		end
		if (pres > longint'(PRES_MAX)) begin
			pres   = longint'(PRES_MAX);
			r.flag = 1'b1;
		end
		r.temperature = temp_c[TOUT_W-1:0];
		r.pressure    = pres[POUT_W-1:0];
		return r;
	endfunction

	task automatic report_failure(input string what);
		failures++;
		if (failures <= 10) $display("mismatch: %s", what);
	endtask

	// one register write; called right after a rising edge, leaves cfg_valid high
	task automatic write_cal_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		// transfer done: mirror it, unknown indexes are dropped by the block
		case (cfg_idx_t'(idx))
			CFG_C1: cal.c1 = value;
			CFG_C2: cal.c2 = value;
			CFG_C3: cal.c3 = value;
			CFG_C4: cal.c4 = value;
			CFG_C5: cal.c5 = value;
			CFG_C6: cal.c6 = value;
			default: ;
		endcase
	endtask

	// all six words, then the unused indexes with junk data
	task automatic write_calibration(input cal_t c);
		@(posedge clk);
		write_cal_reg(CFG_C1, c.c1);
		write_cal_reg(CFG_C2, c.c2);
		write_cal_reg(CFG_C3, c.c3);
		write_cal_reg(CFG_C4, c.c4);
		write_cal_reg(CFG_C5, c.c5);
		write_cal_reg(CFG_C6, c.c6);
		for (int k = int'(CFG_C6) + 1; k < (1 << IDX_W); k++)
			write_cal_reg(IDX_W'(k), CAL_W'($urandom_range(16'hFFFF)));
		cfg_valid <= 1'b0;
		cal_sets++;
	endtask

	// block is idle once nothing is queued, offered or outstanding
	task automatic drain;
		do @(negedge clk);
		while (pending_pairs.size() != 0 || start || expected_readings.size() != 0);
	endtask

	task automatic push_pair(input longint d1, input longint d2);
		conv_pair_t p;
		p.d1 = d1[RAW_W-1:0];
		p.d2 = d2[RAW_W-1:0];
		pending_pairs.push_back(p);
	endtask

	// command driver: predicts at each transfer, then offers the next pair or idles
	always @(posedge clk) begin : drive_cmd
		conv_pair_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				expected_readings.push_back(compensate(raw_pressure, raw_temperature));
				pairs_sent++;
			end
			// a pair still waiting on busy is held as it is
			if (!start || !busy) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					nxt = pending_pairs.pop_front();
					raw_pressure    <= nxt.d1;
					raw_temperature <= nxt.d2;
					start           <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor: every strobe must match the oldest prediction
	always @(posedge clk) begin : check_reading
		reading_t want;
		if (arst_n && result_valid) begin
			if (expected_readings.size() == 0) begin
				report_failure($sformatf("unexpected reading temp %0d pres %0d flag %0b",
					temperature, pressure, out_of_range));
			end else begin
				want = expected_readings.pop_front();
				readings_checked++;
				if (temperature !== want.temperature)
					report_failure($sformatf("temperature exp %0d got %0d",
						want.temperature, temperature));
				if (pressure !== want.pressure)
					report_failure($sformatf("pressure exp %0d got %0d",
						want.pressure, pressure));
				if (out_of_range !== want.flag)
					report_failure($sformatf("out_of_range exp %0b got %0b",
						want.flag, out_of_range));
			end
		end
	end

	// watchdog: too many cycles without any transfer ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("baro_sensor_compensation_tb NOT OK");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		cal_t   set;
		longint d1v, d2v, nom_d2;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// calibration still at reset: all words zero
		push_pair(0, 0);
		push_pair(RAW_MAX, RAW_MAX);
		drain();

		// datasheet calibration, directed corners
		write_calibration(TYPICAL_CAL);
		nom_d2 = longint'(TYPICAL_CAL.c5) * 256;
		push_pair(NOMINAL_D1, 64'sd8077636);         // datasheet example, 20.00 C
		push_pair(NOMINAL_D1, nom_d2);               // exactly 20.00 C, first order only
		push_pair(NOMINAL_D1, nom_d2 - 1);           // just under 20.00 C
		push_pair(NOMINAL_D1, nom_d2 - 500000);      // low temperature branch
		push_pair(NOMINAL_D1, 64'sd7035000);         // just under -15.00 C
		push_pair(NOMINAL_D1, 64'sd7035400);         // exactly -15.00 C
		push_pair(NOMINAL_D1, 64'sd6300000);         // near the cold limit in first order, clamps after correction
		push_pair(NOMINAL_D1, 64'sd6200000);         // cold clamp
		push_pair(NOMINAL_D1, 64'sd10000000);        // hot, in range
		push_pair(NOMINAL_D1, 64'sd10277568);        // hot clamp
		push_pair(NOMINAL_D1, 0);                    // raw temperature at zero
		push_pair(NOMINAL_D1, RAW_MAX);              // raw temperature at full scale
		push_pair(0, nom_d2);                        // pressure clamps low
		push_pair(RAW_MAX, nom_d2);                  // pressure clamps high
		push_pair(64'sd5000000, nom_d2);
		push_pair(64'sd7000000, nom_d2);
		push_pair(64'sd5000000, 64'sd6400000);       // cold and low pressure
		push_pair(RAW_MAX, 0);
		push_pair(0, RAW_MAX);
		push_pair(64'h555555, 64'hAAAAAA);
		push_pair(64'hAAAAAA, 64'h555555);
		drain();

		// random phases; each writes a calibration set and picks one of three idle rates
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 3)
				0: sender_idle_pct = 33;
				1: sender_idle_pct = 67;
				default: sender_idle_pct = 0;
			endcase
			case (ph % 5)
				0: set = TYPICAL_CAL;
				1: set = '1;
				2: set = '0;
				3: begin
					set = TYPICAL_CAL;
					set.c1 = set.c1 + CAL_W'($urandom_range(8191)) - 16'd4096;
					set.c2 = set.c2 + CAL_W'($urandom_range(8191)) - 16'd4096;
					set.c3 = set.c3 + CAL_W'($urandom_range(8191)) - 16'd4096;
					set.c4 = set.c4 + CAL_W'($urandom_range(8191)) - 16'd4096;
					set.c5 = set.c5 + CAL_W'($urandom_range(8191)) - 16'd4096;
					set.c6 = set.c6 + CAL_W'($urandom_range(8191)) - 16'd4096;
				end
				default: set = cal_t'({$urandom, $urandom, $urandom});
			endcase
			write_calibration(set);
			@(negedge clk);
			// mostly plausible readings around the reference point, some full range
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 70)
					d2v = longint'(cal.c5) * 256 + longint'($urandom_range(1 << 22)) - SPREAD;
				else
					d2v = longint'($urandom_range(RAW_MAX));
				if ($urandom_range(99) < 70)
					d1v = NOMINAL_D1 + longint'($urandom_range(1 << 22)) - SPREAD;
				else
					d1v = longint'($urandom_range(RAW_MAX));
				if (d2v < 0) d2v = 0;
				if (d2v > RAW_MAX) d2v = RAW_MAX;
				push_pair(d1v, d2v);
			end
			drain();
		end

		// let any stray strobe show up before the final check
		repeat (PIPE_DEPTH + 4) @(negedge clk);
		if (expected_readings.size() != 0)
			report_failure($sformatf("%0d readings never arrived", expected_readings.size()));
		$display("sent %0d conversion pairs under %0d calibration sets, checked %0d readings",
			pairs_sent, cal_sets, readings_checked);
		$display("%0d failures", failures);
		if (failures == 0) begin
			$display("baro_sensor_compensation_tb OK");
		end else begin
			$display("baro_sensor_compensation_tb NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bsc_pkg.sv
rtl/bsc_cal_regs.sv
rtl/bsc_comp_front.sv
rtl/bsc_pres_back.sv
rtl/baro_sensor_compensation.sv
test/baro_sensor_compensation_tb.sv
